// ===== rtl/mbmf_pkg.sv =====
// Package for the masked box mean filter.
// Holds payload structs, register indexes, reset values and fixed widths.
// No dependencies.
package mbmf_pkg;

  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WS_W       = 3;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int HGT_LIMIT  = 4096;
  // 2 * size * size with size at most 7
  localparam int DEN_W      = 7;
  localparam int NSQ_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE    = 2'd3;

  localparam logic [WS_W-1:0] WS_RESET = 3'd3;
  localparam logic [FW_W-1:0] FW_RESET = 12'd2048;
  localparam logic [FH_W-1:0] FH_RESET = 13'd4096;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        outside_forest;
    logic        small_tree;
    logic        drain;
  } in_item_t;

  typedef struct packed {
    logic [15:0] smoothed_value;
    logic        frame_last;
  } out_item_t;

endpackage

// ===== rtl/mbmf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used for the rounded window mean. No package dependencies.
module mbmf_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, q_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/masked_box_mean_filter_top.sv =====
// Masked box mean filter, top level.
// Depends on mbmf_pkg and mbmf_div.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), one
// transfer per pixel or drain item. Results leave on the out_ channel in
// raster order, delayed by half a window in rows and columns. Drain items
// flush the last pixels of a frame; frame_last marks the final one.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata); a write
// restarts the frame counters and blocks input in the cycle after it.
// Throughput: one item at a time. An item that gives no result only passes
// the decide state; a border or bypassed pixel goes on to the own-pixel read
// and emit; a filtered pixel also scans the window through the single line
// store read port (one window tap a cycle), then uses the bit-serial divider.
// Reset: synchronous, active low; counters clear, registers take defaults,
// line store contents are left as they are.
// Receiver stall: a finished result waits in the output register while the
// next item is taken; processing holds only when a new result is ready.
module masked_box_mean_filter_top #(
  parameter int MAX_WINDOW = mbmf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = mbmf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = mbmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mbmf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbmf_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mbmf_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mbmf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PIX_MAX  = (1 << PIXEL_BITS) - 1;
  localparam int ENT_W    = PIXEL_BITS + 2;
  localparam int RING_W   = $clog2(MAX_WINDOW);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = mbmf_pkg::FH_W;
  localparam int TOT_W    = WEFF_W + ROW_W;
  localparam int DEPTH    = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int HALF_CAP = (MAX_WINDOW - 1) / 2;
  localparam int HALF_W   = $clog2(HALF_CAP + 1);
  localparam int SUM_W    = $clog2(MAX_WINDOW * MAX_WINDOW * PIX_MAX + 1);
  localparam int NUM_W    = SUM_W + 2;
  localparam int DEN_W    = mbmf_pkg::DEN_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_OWN    = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_SUMEND = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [mbmf_pkg::WS_W-1:0] ws_r;
  logic [mbmf_pkg::FW_W-1:0] fw_r;
  logic [mbmf_pkg::FH_W-1:0] fh_r;
  logic                      mode_r;
  logic                      hold_r;

  // derived, registered from the configuration
  logic [WEFF_W-1:0]          w_eff, w_eff_r;
  logic [ROW_W-1:0]           h_eff, h_eff_r;
  logic [mbmf_pkg::WS_W-1:0]  size_eff;
  logic [HALF_W-1:0]          half, half_r;
  logic [mbmf_pkg::DEN_W-1:0] den_r;
  logic [TOT_W-1:0]           total_r, delay_r;
  logic [RING_W-1:0]          span_r;

  // counters
  logic [COL_W-1:0]  col_r, out_col_r;
  logic [ROW_W-1:0]  row_r, out_row_r;
  logic [RING_W-1:0] ring_r, out_ring_r;
  logic [TOT_W-1:0]  in_cnt_r, emitted_r;

  // scan
  logic [RING_W-1:0] sc_ring_r, dr_r, dc_r;
  logic [COL_W-1:0]  sc_col_r, sc_col0_r;
  logic [SUM_W-1:0]  acc_r, sum_fin;
  logic              pend_r, interior_r;
  logic [15:0]       val_r;

  // memory
  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  rd_data_r;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [ENT_W-1:0]  wdata;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;

  logic             out_valid_r;
  mbmf_pkg::out_item_t out_data_r;

  logic accept, wr_pix, emit_ok, can_load, last;
  logic [RING_W:0] ring_start;
  logic [PIXEL_BITS-1:0] own_pix;
  logic bypass;

  function automatic logic [ADDR_W-1:0] addr_of(logic [RING_W-1:0] rg, logic [COL_W-1:0] cl);
    addr_of = ADDR_W'(ADDR_W'(rg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(cl);
  endfunction

  function automatic logic [RING_W-1:0] ring_inc(logic [RING_W-1:0] rg);
    ring_inc = (rg == RING_W'(MAX_WINDOW - 1)) ? '0 : RING_W'(rg + 1'b1);
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= mbmf_pkg::WS_RESET;
      fw_r   <= mbmf_pkg::FW_RESET;
      fh_r   <= mbmf_pkg::FH_RESET;
      mode_r <= 1'b0;
      hold_r <= 1'b1;
    end else begin
      hold_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx)
          mbmf_pkg::CFG_WINDOW_SIZE:  ws_r   <= cfg_wdata[mbmf_pkg::WS_W-1:0];
          mbmf_pkg::CFG_FRAME_WIDTH:  fw_r   <= cfg_wdata[mbmf_pkg::FW_W-1:0];
          mbmf_pkg::CFG_FRAME_HEIGHT: fh_r   <= cfg_wdata[mbmf_pkg::FH_W-1:0];
          mbmf_pkg::CFG_MASK_MODE:    mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (fw_r == '0)                         w_eff = WEFF_W'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH))    w_eff = WEFF_W'(MAX_WIDTH);
    else                                    w_eff = WEFF_W'(fw_r);
    if (fh_r == '0)                                h_eff = ROW_W'(1);
    else if (32'(fh_r) > 32'(mbmf_pkg::HGT_LIMIT)) h_eff = ROW_W'(mbmf_pkg::HGT_LIMIT);
    else                                           h_eff = ROW_W'(fh_r);
    size_eff = (ws_r == '0) ? mbmf_pkg::WS_W'(1) : ws_r;
    half = (32'(size_eff >> 1) > HALF_CAP) ? HALF_W'(HALF_CAP) : HALF_W'(size_eff >> 1);
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_eff;
    h_eff_r <= h_eff;
    half_r  <= half;
    span_r  <= RING_W'({half, 1'b0});
    den_r   <= DEN_W'({mbmf_pkg::NSQ_W'(size_eff * size_eff), 1'b0});
    total_r <= TOT_W'(TOT_W'(w_eff) * TOT_W'(h_eff));
    delay_r <= TOT_W'(TOT_W'(half) * TOT_W'(w_eff)) + TOT_W'(half);
  end

  // ---------------- control ----------------
  assign in_ready = (state_r == S_IDLE) && !hold_r;
  assign accept   = in_valid && in_ready;
  assign wr_pix   = !in_data.drain && (row_r < h_eff_r);
  assign emit_ok  = (emitted_r < total_r) &&
                    ((in_cnt_r >= total_r) ||
                     ({1'b0, in_cnt_r} > ({1'b0, delay_r} + {1'b0, emitted_r})));
  assign can_load = !out_valid_r || out_ready;
  assign last     = ({1'b0, emitted_r} + 1'b1) == {1'b0, total_r};
  assign own_pix  = rd_data_r[PIXEL_BITS-1:0];
  assign bypass   = rd_data_r[PIXEL_BITS] | (mode_r & rd_data_r[PIXEL_BITS+1]);
  assign ring_start = (out_ring_r >= RING_W'(half_r)) ?
                      {1'b0, out_ring_r} - (RING_W+1)'(half_r) :
                      {1'b0, out_ring_r} + (RING_W+1)'(MAX_WINDOW) - (RING_W+1)'(half_r);
  assign sum_fin  = acc_r + SUM_W'(rd_data_r[PIXEL_BITS-1:0]);
  assign div_num  = NUM_W'({sum_fin, 1'b0}) + NUM_W'(den_r >> 1);
  assign div_start = (state_r == S_SUMEND);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = emit_ok ? S_OWN : S_IDLE;
      S_OWN:    state_nxt = (bypass || !interior_r) ? S_EMIT : S_SCAN;
      S_SCAN:   if (dr_r == span_r && dc_r == span_r) state_nxt = S_SUMEND;
      S_SUMEND: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_EMIT;
      S_EMIT:   if (can_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- counters ----------------
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r <= '0; row_r <= '0; ring_r <= '0; in_cnt_r <= '0;
      out_col_r <= '0; out_row_r <= '0; out_ring_r <= '0; emitted_r <= '0;
    end else begin
      if (accept && wr_pix) begin
        in_cnt_r <= in_cnt_r + 1'b1;
        if ((WEFF_W'(col_r) + 1'b1) >= w_eff_r) begin
          col_r  <= '0;
          row_r  <= row_r + 1'b1;
          ring_r <= ring_inc(ring_r);
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (state_r == S_EMIT && can_load) begin
        if (last) begin
          col_r <= '0; row_r <= '0; ring_r <= '0; in_cnt_r <= '0;
          out_col_r <= '0; out_row_r <= '0; out_ring_r <= '0; emitted_r <= '0;
        end else begin
          emitted_r <= emitted_r + 1'b1;
          if ((WEFF_W'(out_col_r) + 1'b1) >= w_eff_r) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_ring_r <= ring_inc(out_ring_r);
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

  // ---------------- window scan ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_DECIDE: begin
        interior_r <= (out_row_r >= ROW_W'(half_r)) &&
                      ((out_row_r + ROW_W'(half_r)) < h_eff_r) &&
                      (WEFF_W'(out_col_r) >= WEFF_W'(half_r)) &&
                      ((WEFF_W'(out_col_r) + WEFF_W'(half_r)) < w_eff_r);
      end
      S_OWN: begin
        val_r     <= 16'(own_pix);
        sc_ring_r <= RING_W'(ring_start);
        sc_col_r  <= out_col_r - COL_W'(half_r);
        sc_col0_r <= out_col_r - COL_W'(half_r);
        dr_r      <= '0;
        dc_r      <= '0;
        acc_r     <= '0;
        pend_r    <= 1'b0;
      end
      S_SCAN: begin
        pend_r <= 1'b1;
        if (pend_r) acc_r <= sum_fin;
        if (dc_r == span_r) begin
          dc_r      <= '0;
          dr_r      <= dr_r + 1'b1;
          sc_col_r  <= sc_col0_r;
          sc_ring_r <= ring_inc(sc_ring_r);
        end else begin
          dc_r     <= dc_r + 1'b1;
          sc_col_r <= sc_col_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          val_r <= (32'(div_quot) > PIX_MAX) ? 16'(PIX_MAX) : 16'(div_quot);
        end
      end
      default: ;
    endcase
  end

  // ---------------- line store ----------------
  assign we    = accept && wr_pix;
  assign waddr = addr_of(ring_r, col_r);
  assign wdata = {in_data.small_tree, in_data.outside_forest,
                  in_data.pixel_value[PIXEL_BITS-1:0]};
  assign re    = (state_r == S_DECIDE) || (state_r == S_SCAN);
  assign raddr = (state_r == S_SCAN) ? addr_of(sc_ring_r, sc_col_r)
                                     : addr_of(out_ring_r, out_col_r);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data_r <= mem[raddr];
  end

  mbmf_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (den_r),
    .done (div_done),
    .quot (div_quot)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && can_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && can_load) begin
      out_data_r.smoothed_value <= val_r;
      out_data_r.frame_last     <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/mbmf_checker.sv =====
// Port-level checker for the masked box mean filter, with its bind.
// Depends on mbmf_pkg and masked_box_mean_filter_top.
module mbmf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input mbmf_pkg::out_item_t                 out_data,
  input logic                                cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while an item is in work");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken before new settings settled");

endmodule

bind masked_box_mean_filter_top mbmf_checker u_mbmf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_we   (cfg_we)
);

// ===== tb/sv/tb.sv =====
// Testbench for masked_box_mean_filter_top.
// Depends on mbmf_pkg and the filter RTL; self-checking against an in-bench predictor.
`timescale 1ns / 1ps

module tb;

  localparam int MW = 7;
  localparam int MXW = 2048;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mbmf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mbmf_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [mbmf_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [mbmf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  masked_box_mean_filter_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [17:0] pixel_lines [MW*MXW];
  int unsigned col_pos, row_pos, sent_count;
  int unsigned win_size, fr_width, fr_height, mmode;
  mbmf_pkg::out_item_t pending_pixels[$];
  int errors = 0, mismatches = 0, results_seen = 0;
  int in_idle_pct = 0, out_stall_pct = 0;
  longint cycles = 0;

  function automatic int unsigned width_eff();
    if (fr_width == 0) return 1;
    return fr_width > MXW ? MXW : fr_width;
  endfunction

  function automatic int unsigned height_eff();
    if (fr_height == 0) return 1;
    return fr_height > mbmf_pkg::HGT_LIMIT ? mbmf_pkg::HGT_LIMIT : fr_height;
  endfunction

  function automatic int unsigned size_eff();
    return win_size == 0 ? 1 : win_size;
  endfunction

  function automatic logic [17:0] line_at(int unsigned r, int unsigned c);
    return pixel_lines[(r % MW) * MXW + (c % MXW)];
  endfunction

  task automatic apply_reg(input logic [mbmf_pkg::CFG_IDX_W-1:0] idx, input int unsigned v);
    case (idx)
      mbmf_pkg::CFG_WINDOW_SIZE:  win_size = v & 7;
      mbmf_pkg::CFG_FRAME_WIDTH:  fr_width = v & 12'hfff;
      mbmf_pkg::CFG_FRAME_HEIGHT: fr_height = v & 13'h1fff;
      mbmf_pkg::CFG_MASK_MODE:    mmode = v & 1;
      default: ;
    endcase
    col_pos = 0; row_pos = 0; sent_count = 0;
  endtask

  // returns 1 if this item causes a result, with that result in res
  function automatic bit predict_filter(input mbmf_pkg::in_item_t it,
                                        output mbmf_pkg::out_item_t res);
    int unsigned w, hg, total, h, dly, in_cnt, ro, co, val, byp, n, sum, mean;
    logic [17:0] own;
    w = width_eff(); hg = height_eff(); total = w * hg;
    h = size_eff() / 2; if (h > (MW - 1) / 2) h = (MW - 1) / 2;
    dly = h * w + h;
    res = '0;
    if (!it.drain && row_pos < hg) begin
      pixel_lines[(row_pos % MW) * MXW + col_pos] =
        {it.small_tree, it.outside_forest, it.pixel_value};
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0; row_pos++;
      end
    end
    in_cnt = row_pos * w + col_pos;
    if (sent_count >= total) return 0;
    if (!(in_cnt >= total || in_cnt > dly + sent_count)) return 0;
    ro = sent_count / w; co = sent_count % w;
    own = line_at(ro, co);
    val = own[15:0];
    byp = own[16] | (mmode != 0 && own[17]);
    if (!byp && ro >= h && ro + h < hg && co >= h && co + h < w) begin
      n = size_eff() * size_eff();
      sum = 0;
      for (int unsigned r = ro - h; r <= ro + h; r++)
        for (int unsigned c = co - h; c <= co + h; c++)
          sum += line_at(r, c) & 18'hffff;
      mean = (2 * sum + n) / (2 * n);
      val = mean > 16'hffff ? 16'hffff : mean;
    end
    res.smoothed_value = val[15:0];
    res.frame_last = (sent_count + 1 == total);
    sent_count++;
    if (res.frame_last) begin
      col_pos = 0; row_pos = 0; sent_count = 0;
    end
    return 1;
  endfunction

  // output side: random stall, compare on transfer
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_pixels.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %h", out_data);
        end else begin
          mbmf_pkg::out_item_t e;
          e = pending_pixels.pop_front();
          if (e.smoothed_value !== out_data.smoothed_value ||
              e.frame_last !== out_data.frame_last) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp value %h last %b, got value %h last %b",
                       e.smoothed_value, e.frame_last,
                       out_data.smoothed_value, out_data.frame_last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input mbmf_pkg::in_item_t it, input bit has_exp,
                           input mbmf_pkg::out_item_t exp_v);
    mbmf_pkg::out_item_t r;
    // idle cycles drop valid so a finished transfer is never offered again
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    if (predict_filter(it, r)) begin
      if (has_exp && r !== exp_v) begin
        errors++;
        if (mismatches++ < 10) $display("directed row: exp %h, predicted %h", exp_v, r);
      end
      pending_pixels.push_back(r);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mbmf_pkg::CFG_IDX_W-1:0] idx, input int unsigned v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v[mbmf_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned ws, input int unsigned w,
                           input int unsigned hh, input int unsigned mm);
    settle();
    write_reg(mbmf_pkg::CFG_WINDOW_SIZE, ws);
    write_reg(mbmf_pkg::CFG_FRAME_WIDTH, w);
    write_reg(mbmf_pkg::CFG_FRAME_HEIGHT, hh);
    write_reg(mbmf_pkg::CFG_MASK_MODE, mm);
  endtask

  // one well-formed frame with random content, drains to flush, plus noise
  task automatic random_frame(input int unsigned w, input int unsigned hh);
    mbmf_pkg::in_item_t it;
    mbmf_pkg::out_item_t none;
    none = '0;
    for (int i = 0; i < w * hh; i++) begin
      it.pixel_value = $urandom_range(9) == 0 ? 16'hffff : 16'($urandom);
      it.outside_forest = ($urandom_range(5) == 0);
      it.small_tree = ($urandom_range(4) == 0);
      it.drain = ($urandom_range(30) == 0);
      send_item(it, 0, none);
      if (it.drain) i--;
    end
    for (int i = 0; i < 4 * w + 4; i++) begin
      it = '0; it.drain = 1'b1;
      if ($urandom_range(7) == 0) begin
        it.drain = 1'b0; it.pixel_value = 16'($urandom);
      end
      send_item(it, 0, none);
    end
  endtask

  typedef struct {
    mbmf_pkg::in_item_t it;
    bit chk;
    mbmf_pkg::out_item_t exp_v;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    int unsigned w, hh, ws;
    mbmf_pkg::out_item_t none;
    none = '0;
    win_size = mbmf_pkg::WS_RESET; fr_width = mbmf_pkg::FW_RESET;
    fr_height = mbmf_pkg::FH_RESET; mmode = 0;
    col_pos = 0; row_pos = 0; sent_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size 1 passes pixels straight through on a 3x2 frame
    write_reg(mbmf_pkg::CFG_WINDOW_SIZE, 1);
    write_reg(mbmf_pkg::CFG_FRAME_WIDTH, 3);
    write_reg(mbmf_pkg::CFG_FRAME_HEIGHT, 2);
    write_reg(mbmf_pkg::CFG_MASK_MODE, 0);
    dir_rows = '{
      '{'{16'h0000, 1'b0, 1'b0, 1'b1}, 0, '0},           // drain with nothing pending
      '{'{16'hffff, 1'b0, 1'b0, 1'b0}, 1, '{16'hffff, 1'b0}},
      '{'{16'h0000, 1'b1, 1'b0, 1'b0}, 1, '{16'h0000, 1'b0}},
      '{'{16'h8001, 1'b0, 1'b1, 1'b0}, 1, '{16'h8001, 1'b0}},
      '{'{16'h1234, 1'b1, 1'b1, 1'b0}, 1, '{16'h1234, 1'b0}},
      '{'{16'h00ff, 1'b0, 1'b0, 1'b0}, 1, '{16'h00ff, 1'b0}},
      '{'{16'hff00, 1'b0, 1'b0, 1'b0}, 1, '{16'hff00, 1'b1}}
    };
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].exp_v);

    // directed: even size 6 on all-max 8x7 saturates at (3,3); mode 1 bypasses
    // the small tree at (3,4)
    set_frame(6, 8, 7, 1);
    for (int i = 0; i < 56; i++) begin
      row.it = '{16'hffff, 1'b0, (i == 28), 1'b0};
      send_item(row.it, 0, none);
    end
    for (int i = 0; i < 30; i++) send_item('{16'h0, 1'b0, 1'b0, 1'b1}, 0, none);

    // size 0 and size 7 at full capacity, width 1, width 0, height 0
    set_frame(0, 4, 3, 0); random_frame(4, 3);
    set_frame(7, 8, 8, 1); random_frame(8, 8);
    set_frame(3, 1, 5, 0); random_frame(1, 5);
    set_frame(5, 0, 0, 0); random_frame(1, 1);
    set_frame(2, 9, 4, 1); random_frame(9, 4);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 68; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 68; end
        default: begin in_idle_pct = 11; out_stall_pct = 11; end
      endcase
      for (int k = 0; k < 4; k++) begin
        ws = $urandom_range(7);
        w = $urandom_range(10, 1);
        hh = $urandom_range(8, 1);
        set_frame(ws, w, hh, $urandom_range(1));
        random_frame(w, hh);
      end
    end
    in_idle_pct = 0; out_stall_pct = 0;
    settle();
    // width and height above their limits are clamped; only set, never filled
    write_reg(mbmf_pkg::CFG_FRAME_WIDTH, 12'hfff);
    write_reg(mbmf_pkg::CFG_FRAME_HEIGHT, 13'h1fff);
    repeat (20) @(posedge clk);

    $display("Covered window sizes 0..7, mask modes, saturation, drains and four idle mixes;");
    $display("%0d results checked.", results_seen);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
